// ===== hdl/mse_pkg.sv =====
// Shared types and constants for the max-tracking stack engine.
`default_nettype none

package mse_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int VALUE_WIDTH = 25;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PMAX = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push;
		logic    report_now;
		status_t err;
		logic    take_top;
		logic    shrink;
		logic    scan_init;
		logic    scan_next;
		logic    below_cap;
		logic    shift_rd;
		logic    shift_wr;
		logic    fetch_cap;
	} mse_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic hit;
		logic more;
	} mse_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/mse_ctrl.sv =====
// Controller state machine: sequences push, pop and pop-max requests.
`default_nettype none

module mse_ctrl import mse_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] cmd,
	input  wire mse_stat_t  stat,
	output logic            busy,
	output mse_ctl_t        ctl
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_BELOW    = 8'b0000_1000,
		S_SHIFT_RD = 8'b0001_0000,
		S_SHIFT_WR = 8'b0010_0000,
		S_FIN      = 8'b0100_0000,
		S_FETCH    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	cmd_t   op;

	assign op   = cmd_t'(cmd);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						CMD_PUSH: begin
							if (stat.full) begin
								ctl.report_now = 1'b1;
								ctl.err        = ST_FULL;
							end else begin
								ctl.push = 1'b1;
							end
						end
						CMD_POP: begin
							if (stat.empty) begin
								ctl.report_now = 1'b1;
								ctl.err        = ST_EMPTY;
							end else begin
								ctl.shrink   = 1'b1;
								ctl.take_top = 1'b1;
								state_d      = S_FETCH;
							end
						end
						CMD_PMAX: begin
							if (stat.empty) begin
								ctl.report_now = 1'b1;
								ctl.err        = ST_EMPTY;
							end else begin
								ctl.scan_init = 1'b1;
								state_d       = S_SCAN_RD;
							end
						end
						default: begin
							ctl.report_now = 1'b1;
							ctl.err        = ST_OK;
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (stat.hit) begin
					state_d = S_BELOW;
				end else begin
					ctl.scan_next = 1'b1;
				end
			end
			S_BELOW: begin
				ctl.below_cap = 1'b1;
				state_d       = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				if (stat.more) begin
					ctl.shift_rd = 1'b1;
					state_d      = S_SHIFT_WR;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SHIFT_WR: begin
				ctl.shift_wr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_FIN: begin
				ctl.shrink = 1'b1;
				state_d    = S_FETCH;
			end
			S_FETCH: begin
				ctl.fetch_cap = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mse_dp.sv =====
// Datapath: entry and running-maximum memories, depth, top and result registers.
`default_nettype none

module mse_dp import mse_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mse_ctl_t                      ctl,
	input  wire logic signed [VALUE_WIDTH-1:0] push_value,
	output mse_stat_t                          stat,
	output logic                               done,
	output logic signed [VALUE_WIDTH-1:0]      removed_value,
	output logic signed [VALUE_WIDTH-1:0]      top_value,
	output logic signed [VALUE_WIDTH-1:0]      max_value,
	output logic        [CNT_W-1:0]            fill_count,
	output logic                               is_empty,
	output logic        [1:0]                  status
);

	logic        [CNT_W-1:0]       depth_q;
	logic                          done_q;
	logic                          below_vld_q;
	logic signed [VALUE_WIDTH-1:0] top_q, max_q, removed_q, below_q;
	logic        [ADDR_W-1:0]      pos_q;

	logic signed [VALUE_WIDTH-1:0] res_removed_q, res_top_q, res_max_q;
	logic        [CNT_W-1:0]       res_fill_q;
	logic                          res_empty_q;
	status_t                       res_status_q;

	logic                          ent_we, mx_we;
	logic        [ADDR_W-1:0]      ent_raddr, ent_waddr, mx_raddr, mx_waddr;
	logic signed [VALUE_WIDTH-1:0] ent_wdata, ent_rdata, mx_wdata, mx_rdata;
	logic signed [VALUE_WIDTH-1:0] push_max, shift_max;
	logic                          new_empty;

	mse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	mse_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_max_ram (
		.clk   (clk),
		.we    (mx_we),
		.waddr (mx_waddr),
		.wdata (mx_wdata),
		.raddr (mx_raddr),
		.rdata (mx_rdata)
	);

	assign stat.empty = (depth_q == '0);
	assign stat.full  = (depth_q == CNT_W'(STACK_DEPTH));
	assign stat.hit   = (ent_rdata == max_q) || (pos_q == '0);
	assign stat.more  = ((CNT_W'(pos_q) + CNT_W'(1)) < depth_q);

	assign push_max  = (stat.empty || (push_value > max_q)) ? push_value : max_q;
	assign shift_max = (!below_vld_q || (ent_rdata > below_q)) ? ent_rdata : below_q;
	assign new_empty = (depth_q == '0);

	always_comb begin
		ent_raddr = pos_q;
		mx_raddr  = pos_q - ADDR_W'(1);
		if (ctl.shrink) begin
			ent_raddr = depth_q[ADDR_W-1:0] - ADDR_W'(2);
			mx_raddr  = depth_q[ADDR_W-1:0] - ADDR_W'(2);
		end else if (ctl.scan_next) begin
			ent_raddr = pos_q - ADDR_W'(1);
		end else if (ctl.shift_rd) begin
			ent_raddr = pos_q + ADDR_W'(1);
		end
	end

	always_comb begin
		ent_we    = ctl.push | ctl.shift_wr;
		mx_we     = ctl.push | ctl.shift_wr;
		ent_waddr = ctl.push ? depth_q[ADDR_W-1:0] : pos_q;
		mx_waddr  = ent_waddr;
		ent_wdata = ctl.push ? push_value : ent_rdata;
		mx_wdata  = ctl.push ? push_max : shift_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			done_q      <= 1'b0;
			below_vld_q <= 1'b0;
		end else begin
			done_q <= ctl.push | ctl.report_now | ctl.fetch_cap;
			if (ctl.push) begin
				depth_q <= depth_q + CNT_W'(1);
			end else if (ctl.shrink) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (ctl.below_cap) begin
				below_vld_q <= (pos_q != '0);
			end else if (ctl.shift_wr) begin
				below_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q         <= push_value;
			max_q         <= push_max;
			res_removed_q <= '0;
			res_top_q     <= push_value;
			res_max_q     <= push_max;
			res_fill_q    <= depth_q + CNT_W'(1);
			res_empty_q   <= 1'b0;
			res_status_q  <= ST_OK;
		end
		if (ctl.report_now) begin
			res_removed_q <= '0;
			res_top_q     <= stat.empty ? '0 : top_q;
			res_max_q     <= stat.empty ? '0 : max_q;
			res_fill_q    <= depth_q;
			res_empty_q   <= stat.empty;
			res_status_q  <= ctl.err;
		end
		if (ctl.take_top) begin
			removed_q <= top_q;
		end
		if (ctl.scan_init) begin
			pos_q     <= depth_q[ADDR_W-1:0] - ADDR_W'(1);
			removed_q <= max_q;
		end
		if (ctl.scan_next) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
		if (ctl.below_cap) begin
			below_q <= mx_rdata;
		end
		if (ctl.shift_wr) begin
			below_q <= shift_max;
			pos_q   <= pos_q + ADDR_W'(1);
		end
		if (ctl.fetch_cap) begin
			top_q         <= ent_rdata;
			max_q         <= mx_rdata;
			res_removed_q <= removed_q;
			res_top_q     <= new_empty ? '0 : ent_rdata;
			res_max_q     <= new_empty ? '0 : mx_rdata;
			res_fill_q    <= depth_q;
			res_empty_q   <= new_empty;
			res_status_q  <= ST_OK;
		end
	end

	assign done          = done_q;
	assign removed_value = res_removed_q;
	assign top_value     = res_top_q;
	assign max_value     = res_max_q;
	assign fill_count    = res_fill_q;
	assign is_empty      = res_empty_q;
	assign status        = res_status_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_W'(STACK_DEPTH))
		else $error("stack depth above capacity");

	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_status_q == ST_FULL)) |-> (res_fill_q == CNT_W'(STACK_DEPTH)))
		else $error("full status on a stack that is not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_empty_q == (res_fill_q == '0)))
		else $error("empty flag disagrees with fill count");

	a_fetch_shrunk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fetch_cap |-> (depth_q == $past(depth_q) - CNT_W'(1)))
		else $error("fetch without a preceding depth decrement");
`endif

endmodule

`default_nettype wire

// ===== hdl/max_stack_engine.sv =====
// Top level of the max-tracking stack engine: controller plus datapath.
//
//   channel   handshake          payload
//   request   start / busy       cmd, push_value
//   result    done (one cycle)   removed_value, top_value, max_value,
//                                fill_count, is_empty, status
//
// A request is taken when start is high and busy is low.
// Push, no-op and error requests: result in the cycle after the request; busy stays low.
// Pop: busy in S_FETCH, which takes the one entry memory read; the result is registered.
// Pop-max: busy while it scans down from the top for the maximum entry, then shifts the
// entries above it down; the scan and shift share the single entry memory read port.
// Reset clears depth to zero; no memory clearing pass. Results are never stalled.
`default_nettype none

module max_stack_engine import mse_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    cmd,
	input  wire logic signed [VALUE_WIDTH-1:0] push_value,
	output logic                               done,
	output logic signed [VALUE_WIDTH-1:0]      removed_value,
	output logic signed [VALUE_WIDTH-1:0]      top_value,
	output logic signed [VALUE_WIDTH-1:0]      max_value,
	output logic        [CNT_W-1:0]            fill_count,
	output logic                               is_empty,
	output logic        [1:0]                  status
);

	mse_ctl_t  ctl;
	mse_stat_t stat;

	mse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	mse_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.push_value    (push_value),
		.stat          (stat),
		.done          (done),
		.removed_value (removed_value),
		.top_value     (top_value),
		.max_value     (max_value),
		.fill_count    (fill_count),
		.is_empty      (is_empty),
		.status        (status)
	);

endmodule

`default_nettype wire

// ===== verif/tb_max_stack_engine.sv =====
// Self-checking testbench for the max-tracking stack engine with a result scoreboard.
package tb_max_stack_pkg;

	import mse_pkg::*;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] removed;
		logic [VALUE_WIDTH-1:0] top;
		logic [VALUE_WIDTH-1:0] peak;
		logic [CNT_W-1:0]       fill;
		logic                   empty;
		status_t                code;
	} stack_report_t;

	class max_stack_scoreboard;
		logic signed [VALUE_WIDTH-1:0] entries [STACK_DEPTH];
		logic signed [VALUE_WIDTH-1:0] running_max [STACK_DEPTH];
		int                            depth;
		stack_report_t                 expected_reports [$];
		int                            errors;
		int                            checked;
		int                            requests;
		int                            full_pushes;
		int                            empty_pops;
		int                            max_removals;
		int                            peak_depth;

		function new();
			depth = 0;
			errors = 0;
			checked = 0;
			requests = 0;
			full_pushes = 0;
			empty_pops = 0;
			max_removals = 0;
			peak_depth = 0;
		endfunction

		function void refresh_max(int from);
			for (int i = from; i < depth; i++) begin
				if (i == 0) begin
					running_max[i] = entries[i];
				end else begin
					running_max[i] = (entries[i] > running_max[i-1]) ? entries[i] :
						running_max[i-1];
				end
			end
		endfunction

		function void note_request(cmd_t op, logic signed [VALUE_WIDTH-1:0] value);
			stack_report_t                 rpt;
			logic signed [VALUE_WIDTH-1:0] mx;
			int                            pos;
			rpt = '0;
			rpt.code = ST_OK;
			requests++;
			case (op)
			CMD_PUSH: begin
				if (depth >= STACK_DEPTH) begin
					rpt.code = ST_FULL;
					full_pushes++;
				end else begin
					entries[depth] = value;
					depth++;
					refresh_max(depth - 1);
				end
			end
			CMD_POP: begin
				if (depth == 0) begin
					rpt.code = ST_EMPTY;
					empty_pops++;
				end else begin
					depth--;
					rpt.removed = entries[depth];
				end
			end
			CMD_PMAX: begin
				if (depth == 0) begin
					rpt.code = ST_EMPTY;
					empty_pops++;
				end else begin
					mx = running_max[depth-1];
					pos = depth - 1;
					while (pos > 0 && entries[pos] != mx)
						pos--;
					rpt.removed = mx;
					for (int i = pos; i + 1 < depth; i++)
						entries[i] = entries[i+1];
					depth--;
					refresh_max(pos);
					max_removals++;
				end
			end
			default: begin
			end
			endcase
			if (depth == 0) begin
				rpt.empty = 1'b1;
			end else begin
				rpt.top = entries[depth-1];
				rpt.peak = running_max[depth-1];
			end
			rpt.fill = CNT_W'(depth);
			if (depth > peak_depth)
				peak_depth = depth;
			expected_reports = {expected_reports, rpt};
		endfunction

		function void compare_field(string field, logic signed [63:0] want,
			logic signed [63:0] seen);
			if (want !== seen) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on result %0d, %0s: expected %0d, got %0d",
						checked, field, want, seen);
			end
		endfunction

		function void check_result(stack_report_t got);
			stack_report_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with no request pending: fill %0d, status %0d",
						got.fill, got.code);
				return;
			end
			want = expected_reports.pop_front();
			checked++;
			compare_field("removed_value", $signed(want.removed), $signed(got.removed));
			compare_field("top_value", $signed(want.top), $signed(got.top));
			compare_field("max_value", $signed(want.peak), $signed(got.peak));
			compare_field("fill_count", want.fill, got.fill);
			compare_field("is_empty", want.empty, got.empty);
			compare_field("status", want.code, got.code);
		endfunction
	endclass

endpackage

module tb_max_stack_engine;

	import mse_pkg::*;
	import tb_max_stack_pkg::*;

	localparam int WATCHDOG_LIMIT = 16000;
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [1:0]                    cmd = CMD_NOP;
	logic signed [VALUE_WIDTH-1:0] push_value = '0;
	logic                          busy;
	logic                          done;
	logic signed [VALUE_WIDTH-1:0] removed_value;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic signed [VALUE_WIDTH-1:0] max_value;
	logic [CNT_W-1:0]              fill_count;
	logic                          is_empty;
	logic [1:0]                    status;

	max_stack_scoreboard stack_check;
	stack_report_t       observed;
	int                  idle_cycles = 0;
	int                  issued = 0;
	bit                  no_gaps = 1'b0;

	max_stack_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.push_value    (push_value),
		.done          (done),
		.removed_value (removed_value),
		.top_value     (top_value),
		.max_value     (max_value),
		.fill_count    (fill_count),
		.is_empty      (is_empty),
		.status        (status)
	);

	always #5 clk = ~clk;

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		int small_val;
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			small_val = $urandom_range(0, 6);
			return VALUE_WIDTH'(small_val - 3);
		end
		3: begin
			return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		end
		4: begin
			return $urandom_range(0, 1) ? VALUE_WIDTH'(VAL_MAX - $urandom_range(0, 3)) :
				VALUE_WIDTH'(VAL_MIN + $urandom_range(0, 3));
		end
		default: begin
			return VALUE_WIDTH'($urandom);
		end
		endcase
	endfunction

	function automatic cmd_t choose_op(int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return CMD_PUSH;
		else if (roll < push_pct + (96 - push_pct) / 2)
			return CMD_POP;
		else if (roll < 96)
			return CMD_PMAX;
		return CMD_NOP;
	endfunction

	task automatic issue(cmd_t op, logic signed [VALUE_WIDTH-1:0] value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		push_value <= value;
		do @(posedge clk); while (busy);
		stack_check.note_request(op, value);
		issued++;
		if (issued % 64 == 0)
			no_gaps = ($urandom_range(0, 3) == 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			observed = '{removed_value, top_value, max_value, fill_count, is_empty,
				status_t'(status)};
			stack_check.check_result(observed);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					stack_check.expected_reports.size());
				$display("tb_max_stack_engine: errors");
				$finish;
			end
		end
	end

	initial begin
		stack_check = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack errors, extremes, equal maxima, gap closing
		issue(CMD_POP, pick_value());
		issue(CMD_PMAX, pick_value());
		issue(CMD_NOP, pick_value());
		issue(CMD_PUSH, VAL_MAX);
		issue(CMD_PUSH, VAL_MIN);
		issue(CMD_NOP, pick_value());
		issue(CMD_PMAX, pick_value());
		issue(CMD_POP, pick_value());
		issue(CMD_PUSH, VALUE_WIDTH'(0));
		issue(CMD_PUSH, VALUE_WIDTH'(-1));
		issue(CMD_PUSH, VALUE_WIDTH'(7));
		issue(CMD_PUSH, VALUE_WIDTH'(3));
		issue(CMD_PUSH, VALUE_WIDTH'(7));
		issue(CMD_PUSH, VALUE_WIDTH'(1));
		issue(CMD_PMAX, pick_value());
		issue(CMD_POP, pick_value());
		issue(CMD_POP, pick_value());
		issue(CMD_PMAX, pick_value());
		issue(CMD_PMAX, pick_value());
		issue(CMD_PUSH, VAL_MIN);
		issue(CMD_PMAX, pick_value());
		issue(CMD_POP, pick_value());
		issue(CMD_PMAX, pick_value());

		// shallow stack, frequent duplicates
		repeat (550) begin
			if (stack_check.depth < 4)
				issue(choose_op(60), pick_value());
			else if (stack_check.depth > 24)
				issue(choose_op(30), pick_value());
			else
				issue(choose_op(48), pick_value());
		end

		// fill to capacity, then work near full
		while (stack_check.depth < STACK_DEPTH)
			issue(CMD_PUSH, pick_value());
		repeat (3) issue(CMD_PUSH, pick_value());
		repeat (150) issue(choose_op(55), pick_value());

		start <= 1'b0;
		while (stack_check.expected_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d requests: %0d pop-max removals, %0d pushes on full, %0d pops on empty",
			stack_check.requests, stack_check.max_removals, stack_check.full_pushes,
			stack_check.empty_pops);
		$display("peak depth %0d, %0d results checked, %0d mismatches",
			stack_check.peak_depth, stack_check.checked, stack_check.errors);
		if (stack_check.errors == 0)
			$display("tb_max_stack_engine: clean");
		else
			$display("tb_max_stack_engine: errors");
		$finish;
	end

endmodule

// ===== max_stack_engine.f =====
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/mse_ctrl.sv
hdl/mse_dp.sv
hdl/max_stack_engine.sv
verif/tb_max_stack_engine.sv
